FILE: design/fbb_pkg.sv
package fbb_pkg;

   // Command codes carried on req_cmd.
   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_SET    = 3'd1;
   localparam logic [2:0] CMD_GET    = 3'd2;
   localparam logic [2:0] CMD_FILL   = 3'd3;
   localparam logic [2:0] CMD_SPRITE = 3'd4;

   // Register indexes on the csr port.
   localparam logic [1:0] REG_FRAME_WIDTH     = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT    = 2'd1;
   localparam logic [1:0] REG_TRANSPARENT_KEY = 2'd2;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_FILL,
      ST_READ,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture and clip a new command
      logic calc;   // form the start address
      logic step;   // write one pixel and advance the raster
      logic read;   // read one pixel from the store
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic write_needed;  // the clipped command writes at least one pixel
      logic read_needed;   // an on-screen get
      logic last;          // the raster is at its final pixel
   } ctrl_status_type;

endpackage

FILE: design/fbb_ctrl.sv
module fbb_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output logic                     rsp_valid,
   output fbb_pkg::ctrl_cmd_type    ctl,
   input  fbb_pkg::ctrl_status_type stat
);
   import fbb_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (stat.write_needed) begin
               state_in = ST_FILL;
            end else if (stat.read_needed) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_FILL: begin
            if (stat.last) begin
               state_in = ST_RESP;
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      ctl       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            ctl.load = start;
         end
         ST_CALC: begin
            ctl.calc = 1'b1;
         end
         ST_FILL: begin
            ctl.step = 1'b1;
         end
         ST_READ: begin
            ctl.read = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // The completion strobe lasts exactly one cycle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("completion strobe held for more than one cycle");

   // An accepted command keeps the block busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("busy not raised after an accepted command");

   // A store access, pixel write or read, never happens while the block reports idle.
   assert property (@(posedge clock) disable iff (reset) (ctl.step || ctl.read) |-> busy)
      else $error("store access outside a command");

   // After the completion strobe the controller returns to idle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !busy)
      else $error("controller did not return to idle after completion");

endmodule

FILE: design/fbb_datapath.sv
module fbb_datapath #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int COLOR_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_wdata,
   input  logic [2:0]               req_cmd,
   input  logic signed [15:0]       req_point_a_x,
   input  logic signed [15:0]       req_point_a_y,
   input  logic signed [15:0]       req_point_b_x,
   input  logic signed [15:0]       req_point_b_y,
   input  logic [31:0]              req_pixel_color,
   input  fbb_pkg::ctrl_cmd_type    ctl,
   output fbb_pkg::ctrl_status_type stat,
   output logic [31:0]              rsp_read_color,
   output logic                     rsp_in_bounds
);
   import fbb_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = (AW > 19) ? AW : 19;

   // Configuration registers.
   logic [8:0]  fw_ff;
   logic [8:0]  fh_ff;
   logic [31:0] key_ff;

   // Captured command.
   logic                  get_ff;
   logic                  inb_ff;
   logic                  wr_ff;
   logic [COLOR_BITS-1:0] color_ff;
   logic [8:0]            x0_ff;
   logic [8:0]            x1_ff;
   logic [8:0]            y0_ff;
   logic [8:0]            y1_ff;

   // Raster walk.
   logic [8:0]    x_ff;
   logic [8:0]    y_ff;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] row_ff;

   // Frame store and its read register.
   logic [COLOR_BITS-1:0] mem [DEPTH];
   logic [COLOR_BITS-1:0] rdata_ff;

   logic [8:0]            eff_w;
   logic [8:0]            eff_h;
   logic [COLOR_BITS-1:0] key_m;
   logic [COLOR_BITS-1:0] color_m;
   logic signed [17:0]    cx0;
   logic signed [17:0]    cx1;
   logic signed [17:0]    cy0;
   logic signed [17:0]    cy1;
   logic                  inb;
   logic                  wr;
   logic [17:0]           prod;
   logic [PW-1:0]         start_addr;

   // Active screen size, limited to the store dimensions.
   assign eff_w   = ({23'd0, fw_ff} > 32'(MAX_WIDTH))  ? 9'(MAX_WIDTH)  : fw_ff;
   assign eff_h   = ({23'd0, fh_ff} > 32'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : fh_ff;
   assign key_m   = key_ff[COLOR_BITS-1:0];
   assign color_m = req_pixel_color[COLOR_BITS-1:0];

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff  <= 9'd256;
         fh_ff  <= 9'd256;
         key_ff <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH:     fw_ff  <= csr_wdata[8:0];
            REG_FRAME_HEIGHT:    fh_ff  <= csr_wdata[8:0];
            REG_TRANSPARENT_KEY: key_ff <= csr_wdata;
            default: begin
               fw_ff <= fw_ff;
            end
         endcase
      end
   end

   // Clip the command to the screen. Every command is turned into a
   // rectangle; a single pixel is a rectangle with equal corners.
   always_comb begin
      logic signed [17:0] ax;
      logic signed [17:0] ay;
      logic signed [17:0] bx;
      logic signed [17:0] by;
      logic signed [17:0] wm1;
      logic signed [17:0] hm1;
      logic signed [17:0] lox;
      logic signed [17:0] hix;
      logic signed [17:0] loy;
      logic signed [17:0] hiy;
      ax  = 18'(req_point_a_x);
      ay  = 18'(req_point_a_y);
      bx  = 18'(req_point_b_x);
      by  = 18'(req_point_b_y);
      wm1 = signed'({9'd0, eff_w}) - 18'sd1;
      hm1 = signed'({9'd0, eff_h}) - 18'sd1;
      case (req_cmd)
         CMD_CLEAR: begin
            lox = 18'sd0;
            hix = wm1;
            loy = 18'sd0;
            hiy = hm1;
         end
         CMD_SET, CMD_GET: begin
            lox = ax;
            hix = ax;
            loy = ay;
            hiy = ay;
         end
         CMD_FILL: begin
            lox = (ax < bx) ? ax : bx;
            hix = (ax < bx) ? bx : ax;
            loy = (ay < by) ? ay : by;
            hiy = (ay < by) ? by : ay;
         end
         CMD_SPRITE: begin
            lox = ax + bx;
            hix = ax + bx;
            loy = ay + by;
            hiy = ay + by;
         end
         default: begin
            lox = 18'sd0;
            hix = -18'sd1;
            loy = 18'sd0;
            hiy = -18'sd1;
         end
      endcase
      cx0 = (lox < 18'sd0) ? 18'sd0 : lox;
      cx1 = (hix > wm1) ? wm1 : hix;
      cy0 = (loy < 18'sd0) ? 18'sd0 : loy;
      cy1 = (hiy > hm1) ? hm1 : hiy;
      inb = (cx0 <= cx1) && (cy0 <= cy1);
      case (req_cmd)
         CMD_CLEAR, CMD_SET, CMD_FILL: wr = inb;
         CMD_SPRITE:                   wr = inb && (color_m != key_m);
         default:                      wr = 1'b0;
      endcase
   end

   // Capture the clipped command.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         get_ff   <= (req_cmd == CMD_GET);
         inb_ff   <= inb;
         wr_ff    <= wr;
         color_ff <= color_m;
         x0_ff    <= cx0[8:0];
         x1_ff    <= cx1[8:0];
         y0_ff    <= cy0[8:0];
         y1_ff    <= cy1[8:0];
      end
   end

   // Start address of the rectangle: one multiply by the row stride.
   assign prod       = y0_ff * eff_w;
   assign start_addr = PW'(prod) + PW'(x0_ff);

   // Raster walk, one pixel per cycle, stepping the row base by the stride.
   always_ff @(posedge clock) begin
      if (ctl.calc) begin
         x_ff    <= x0_ff;
         y_ff    <= y0_ff;
         addr_ff <= start_addr[AW-1:0];
         row_ff  <= start_addr[AW-1:0];
      end else if (ctl.step) begin
         if (x_ff == x1_ff) begin
            x_ff    <= x0_ff;
            y_ff    <= y_ff + 9'd1;
            row_ff  <= row_ff + AW'(eff_w);
            addr_ff <= row_ff + AW'(eff_w);
         end else begin
            x_ff    <= x_ff + 9'd1;
            addr_ff <= addr_ff + AW'(1);
         end
      end
   end

   // Frame store: one write or one read per cycle.
   always_ff @(posedge clock) begin
      if (ctl.step) begin
         mem[addr_ff] <= color_ff;
      end
      if (ctl.read) begin
         rdata_ff <= mem[addr_ff];
      end
   end

   // Status to the controller.
   assign stat.write_needed = wr_ff;
   assign stat.read_needed  = get_ff && inb_ff;
   assign stat.last         = (x_ff == x1_ff) && (y_ff == y1_ff);

   // Result fields.
   assign rsp_read_color = get_ff ? (inb_ff ? 32'(rdata_ff) : 32'(key_m)) : 32'd0;
   assign rsp_in_bounds  = inb_ff;

endmodule

FILE: design/framebuffer_fill_and_blit_core.sv
// After the accepting edge the controller forms the start address (ST_CALC), then writes
// the pixels (ST_FILL) or reads one for an on-screen get (ST_READ), then raises the strobe.
// The next command is taken in the cycle after the strobe; clear and fill run at one
// pixel per cycle, bounded by the single write port of the frame store.
// Reset (synchronous, active high) returns the controller to idle and the registers to
// 256 x 256 with key 0; the store is not cleared. The receiver cannot stall results.
module framebuffer_fill_and_blit_core #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int COLOR_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic signed [15:0] req_point_a_x,
   input  logic signed [15:0] req_point_a_y,
   input  logic signed [15:0] req_point_b_x,
   input  logic signed [15:0] req_point_b_y,
   input  logic [31:0]        req_pixel_color,
   output logic               rsp_valid,
   output logic [31:0]        rsp_read_color,
   output logic               rsp_in_bounds,
   output logic               rsp_done_res,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import fbb_pkg::*;

   ctrl_cmd_type    ctl;
   ctrl_status_type stat;

   // Sequencer.
   fbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl),
      .stat      (stat)
   );

   // Clipping, address generation and frame store.
   fbb_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COLOR_BITS (COLOR_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_cmd),
      .req_point_a_x   (req_point_a_x),
      .req_point_a_y   (req_point_a_y),
      .req_point_b_x   (req_point_b_x),
      .req_point_b_y   (req_point_b_y),
      .req_pixel_color (req_pixel_color),
      .ctl             (ctl),
      .stat            (stat),
      .rsp_read_color  (rsp_read_color),
      .rsp_in_bounds   (rsp_in_bounds)
   );

   // Every command completes.
   assign rsp_done_res = 1'b1;

endmodule
